// ===== hw/rtl/tsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tsc_pkg;

   localparam int ALPHA    = 26;
   localparam int LETTER_Z = 25;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ABSENT   = 3'd1;
   localparam logic [2:0] ST_POOL     = 3'd2;
   localparam logic [2:0] ST_TOO_LONG = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   typedef enum logic [3:0] {
      S_CLR,
      S_COLLECT,
      S_W_LET,
      S_W_LINK,
      S_W_CHK,
      S_W_PFX,
      S_W_END,
      S_W_DEC,
      S_I_LET,
      S_I_A,
      S_I_INC,
      S_I_END,
      S_D_LET,
      S_D_RD,
      S_D_WR,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/trie_string_counter.sv =====
// Counting prefix tree over lowercase strings. Letters stream in one per beat
// (tdata, clamped to z); the beat with tlast closes the string and its tuser
// selects insert, delete or find, and one response beat follows. After reset
// a clearing pass zeroes the link and count memories, and no request beat is
// taken until it ends. Letters are taken one per cycle while collecting.
// At the close, the walk reads each letter from the buffer, reads its link
// and the prefix count of the node followed, then advances; it stops at a
// letter whose link is missing and then reads the end count. An insert then
// bumps the prefix count of each existing path node, claims each new node
// from the pool and writes the end count; a delete lowers the path's counts.
// The response sits in its own register, so the next string can be collected
// and processed while it waits. Nodes are never reclaimed; a full pool
// refuses the insert.
`timescale 1ns / 1ps
`default_nettype none
module trie_string_counter #(
   parameter int NODES       = 64,
   parameter int MAX_LEN     = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [4:0] letter, zero padded
   input  wire logic [2:0] req_tuser,   // [1:0] req_type, [2] no_letter
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] found, [3:1] status, zero padded
);
   import tsc_pkg::*;

   localparam int LINKS = NODES * ALPHA;
   localparam int NW    = $clog2(NODES);
   localparam int AW    = $clog2(LINKS);
   localparam int LW    = $clog2(MAX_LEN + 1);
   localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int FW    = $clog2(NODES + 1);
   localparam int PW    = ((FW > LW) ? FW : LW) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [NW-1:0]          lnk_mem  [LINKS];
   logic [COUNT_WIDTH-1:0] pfx_mem  [NODES];
   logic [COUNT_WIDTH-1:0] end_mem  [NODES];
   logic [4:0]             lbuf_mem [MAX_LEN];
   logic [NW-1:0]          pbuf_mem [MAX_LEN];

   logic [NW-1:0]          lnk_rd_ff, pbuf_rd_ff;
   logic [COUNT_WIDTH-1:0] pfx_rd_ff, end_rd_ff;
   logic [4:0]             lbuf_rd_ff;

   logic                   lnk_we, pfx_we, end_we, lbuf_we, pbuf_we;
   logic [AW-1:0]          lnk_wa, lnk_ra;
   logic [NW-1:0]          lnk_wd, pfx_wa, pfx_ra, end_wa, end_ra, pbuf_wd;
   logic [COUNT_WIDTH-1:0] pfx_wd, end_wd;
   logic [IW-1:0]          lbuf_wa, lbuf_ra, pbuf_wa, pbuf_ra;
   logic [4:0]             lbuf_wd;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [LW-1:0]          len_ff, len_in, i_ff, i_in, matched_ff, matched_in;
   logic                   ovl_ff, ovl_in, full_ff, full_in;
   logic [1:0]             op_ff, op_in;
   logic [NW-1:0]          node_ff, node_in, cur_ff, cur_in;
   logic [4:0]             letter_ff, letter_in;
   logic [COUNT_WIDTH-1:0] end_ff, end_in;
   logic [FW-1:0]          free_ff, free_in;
   logic                   res_found_ff, res_found_in, rsp_valid_ff, rsp_valid_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;

   logic                   req_beat, ovl_next, hit, pool_short;
   logic [4:0]             req_letter;
   logic [COUNT_WIDTH-1:0] pfx_dec;

   function automatic logic [AW-1:0] lnk_addr(input logic [NW-1:0] node,
                                              input logic [4:0] letter);
      return AW'(node) * AW'(ALPHA) + AW'(letter);
   endfunction

   assign req_tready = (state_ff == S_COLLECT);
   assign req_beat   = req_tvalid && req_tready;
   assign req_letter = (req_tdata[4:0] > 5'(LETTER_Z)) ? 5'(LETTER_Z) : req_tdata[4:0];
   assign ovl_next   = ovl_ff || (!req_tuser[2] && (len_ff == LW'(MAX_LEN)));
   assign hit        = (matched_ff == len_ff) && (end_rd_ff != '0);
   assign pool_short = (PW'(free_ff) + PW'(len_ff) - PW'(matched_ff)) > PW'(NODES);
   assign pfx_dec    = pfx_rd_ff - COUNT_WIDTH'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_found_ff};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      len_in        = len_ff;
      i_in          = i_ff;
      matched_in    = matched_ff;
      ovl_in        = ovl_ff;
      full_in       = full_ff;
      op_in         = op_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      letter_in     = letter_ff;
      end_in        = end_ff;
      free_in       = free_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      lnk_we  = 1'b0;  lnk_wa  = '0;  lnk_wd  = '0;  lnk_ra  = '0;
      pfx_we  = 1'b0;  pfx_wa  = '0;  pfx_wd  = '0;  pfx_ra  = '0;
      end_we  = 1'b0;  end_wa  = '0;  end_wd  = '0;  end_ra  = '0;
      lbuf_we = 1'b0;  lbuf_wa = len_ff[IW-1:0];  lbuf_wd = req_letter;
      lbuf_ra = i_ff[IW-1:0];
      pbuf_we = 1'b0;  pbuf_wa = i_ff[IW-1:0];  pbuf_wd = lnk_rd_ff;
      pbuf_ra = i_ff[IW-1:0];
      case (state_ff)
         S_CLR: begin
            lnk_we = 1'b1;
            lnk_wa = clr_ff;
            if (clr_ff < AW'(NODES)) begin
               pfx_we = 1'b1;
               pfx_wa = clr_ff[NW-1:0];
               end_we = 1'b1;
               end_wa = clr_ff[NW-1:0];
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(LINKS - 1)) begin
               state_in = S_COLLECT;
            end
         end
         S_COLLECT: begin
            if (req_beat) begin
               if (!req_tuser[2]) begin
                  if (len_ff < LW'(MAX_LEN)) begin
                     lbuf_we = 1'b1;
                     len_in  = len_ff + LW'(1);
                  end else begin
                     ovl_in = 1'b1;
                  end
               end
               if (req_tlast) begin
                  op_in   = req_tuser[1:0];
                  i_in    = '0;
                  node_in = '0;
                  full_in = 1'b0;
                  if (ovl_next) begin
                     res_found_in  = 1'b0;
                     res_status_in = ST_TOO_LONG;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_W_LET;
                  end
               end
            end
         end
         S_W_LET: begin
            state_in = (i_ff == len_ff) ? S_W_END : S_W_LINK;
         end
         S_W_LINK: begin
            lnk_ra   = lnk_addr(node_ff, lbuf_rd_ff);
            state_in = S_W_CHK;
         end
         S_W_CHK: begin
            if (lnk_rd_ff == '0) begin
               state_in = S_W_END;
            end else begin
               node_in  = lnk_rd_ff;
               pbuf_we  = 1'b1;
               pfx_ra   = lnk_rd_ff;
               state_in = S_W_PFX;
            end
         end
         S_W_PFX: begin
            if (pfx_rd_ff == COUNT_MAX) begin
               full_in = 1'b1;
            end
            i_in     = i_ff + LW'(1);
            state_in = S_W_LET;
         end
         S_W_END: begin
            end_ra     = node_ff;
            matched_in = i_ff;
            state_in   = S_W_DEC;
         end
         S_W_DEC: begin
            i_in     = '0;
            res_found_in  = 1'b0;
            res_status_in = ST_OK;
            if (op_ff == OP_INSERT) begin
               if (pool_short) begin
                  res_status_in = ST_POOL;
                  state_in      = S_DONE;
               end else if (full_ff ||
                            ((matched_ff == len_ff) && (end_rd_ff == COUNT_MAX))) begin
                  res_status_in = ST_OVERFLOW;
                  state_in      = S_DONE;
               end else begin
                  end_in   = end_rd_ff;
                  node_in  = '0;
                  state_in = S_I_LET;
               end
            end else if (!hit) begin
               res_status_in = ST_ABSENT;
               state_in      = S_DONE;
            end else if (op_ff == OP_DELETE) begin
               end_we   = 1'b1;
               end_wa   = node_ff;
               end_wd   = end_rd_ff - COUNT_WIDTH'(1);
               node_in  = '0;
               state_in = S_D_LET;
            end else begin
               res_found_in = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_I_LET: begin
            state_in = (i_ff == len_ff) ? S_I_END : S_I_A;
         end
         S_I_A: begin
            if (i_ff < matched_ff) begin
               pfx_ra   = pbuf_rd_ff;
               cur_in   = pbuf_rd_ff;
               state_in = S_I_INC;
            end else begin
               lnk_we   = 1'b1;
               lnk_wa   = lnk_addr(node_ff, lbuf_rd_ff);
               lnk_wd   = free_ff[NW-1:0];
               pfx_we   = 1'b1;
               pfx_wa   = free_ff[NW-1:0];
               pfx_wd   = COUNT_WIDTH'(1);
               node_in  = free_ff[NW-1:0];
               free_in  = free_ff + FW'(1);
               i_in     = i_ff + LW'(1);
               state_in = S_I_LET;
            end
         end
         S_I_INC: begin
            pfx_we   = 1'b1;
            pfx_wa   = cur_ff;
            pfx_wd   = pfx_rd_ff + COUNT_WIDTH'(1);
            node_in  = cur_ff;
            i_in     = i_ff + LW'(1);
            state_in = S_I_LET;
         end
         S_I_END: begin
            end_we   = 1'b1;
            end_wa   = node_ff;
            end_wd   = (matched_ff == len_ff) ? end_ff + COUNT_WIDTH'(1) : COUNT_WIDTH'(1);
            state_in = S_DONE;
         end
         S_D_LET: begin
            state_in = (i_ff == len_ff) ? S_DONE : S_D_RD;
         end
         S_D_RD: begin
            cur_in    = pbuf_rd_ff;
            letter_in = lbuf_rd_ff;
            pfx_ra    = pbuf_rd_ff;
            state_in  = S_D_WR;
         end
         S_D_WR: begin
            // node_ff is the parent of the node being released here.
            pfx_we = 1'b1;
            pfx_wa = cur_ff;
            pfx_wd = pfx_dec;
            if (pfx_dec == '0) begin
               lnk_we = 1'b1;
               lnk_wa = lnk_addr(node_ff, letter_ff);
               lnk_wd = '0;
            end
            node_in  = cur_ff;
            i_in     = i_ff + LW'(1);
            state_in = S_D_LET;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               len_in        = '0;
               ovl_in        = 1'b0;
               state_in      = S_COLLECT;
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[lnk_wa] <= lnk_wd;
      end
      lnk_rd_ff <= lnk_mem[lnk_ra];
      if (pfx_we) begin
         pfx_mem[pfx_wa] <= pfx_wd;
      end
      pfx_rd_ff <= pfx_mem[pfx_ra];
      if (end_we) begin
         end_mem[end_wa] <= end_wd;
      end
      end_rd_ff <= end_mem[end_ra];
      if (lbuf_we) begin
         lbuf_mem[lbuf_wa] <= lbuf_wd;
      end
      lbuf_rd_ff <= lbuf_mem[lbuf_ra];
      if (pbuf_we) begin
         pbuf_mem[pbuf_wa] <= pbuf_wd;
      end
      pbuf_rd_ff <= pbuf_mem[pbuf_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         len_ff       <= '0;
         ovl_ff       <= 1'b0;
         free_ff      <= FW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
         ovl_ff       <= ovl_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      matched_ff    <= matched_in;
      full_ff       <= full_in;
      op_ff         <= op_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      letter_ff     <= letter_in;
      end_ff        <= end_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTH
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == ST_OK)
      else $error("found set with a non-ok status");
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FW'(NODES))
      else $error("node pool allocated past its end");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_LEN))
      else $error("letter count past the buffer depth");
   a_clr_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> !rsp_valid_ff && !req_tready)
      else $error("traffic during the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== test/tb_trie_string_counter.sv =====
`timescale 1ns / 1ps
module tb_trie_string_counter;
   import tsc_pkg::*;

   localparam int NODES   = 64;
   localparam int MAX_LEN = 32;
   localparam int CNT_MAX = 16'hFFFF;
   localparam logic [1:0] OP_FIND = 2'd2;
   localparam logic [1:0] OP_ALT_FIND = 2'd3;
   localparam int ITEM_TARGET = 1050;

   // Keeps its own copy of the trie and the queue of expected response beats.
   class trie_scoreboard;
      bit [5:0]  links [NODES*ALPHA];
      bit [15:0] end_cnt [NODES];
      bit [15:0] pfx_cnt [NODES];
      int unsigned next_node;
      bit [4:0]  letters [MAX_LEN];
      bit [5:0]  path [MAX_LEN];
      int unsigned n_letters;
      bit overlong;
      bit [3:0]  expected_rsp [$];
      int errors;

      function new();
         next_node = 1;
         n_letters = 0;
         overlong = 0;
         errors = 0;
      endfunction

      function void report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endfunction

      function int unsigned walk(output int unsigned node, output bit full);
         int unsigned i;
         int unsigned nx;
         node = 0;
         i = 0;
         full = 0;
         while (i < n_letters) begin
            nx = links[node*ALPHA + letters[i]];
            if (nx == 0) break;
            node = nx;
            path[i] = nx[5:0];
            if (pfx_cnt[node] == CNT_MAX) full = 1;
            i++;
         end
         return i;
      endfunction

      function bit present();
         int unsigned node;
         int unsigned matched;
         bit full;
         matched = walk(node, full);
         return (matched == n_letters) && (end_cnt[node] != 0);
      endfunction

      function logic [2:0] insert_word();
         int unsigned node;
         int unsigned matched;
         int unsigned idx;
         bit full;
         matched = walk(node, full);
         if (next_node + (n_letters - matched) > NODES) return ST_POOL;
         if (full || (matched == n_letters && end_cnt[node] == CNT_MAX)) return ST_OVERFLOW;
         node = 0;
         for (int i = 0; i < n_letters; i++) begin
            idx = node*ALPHA + letters[i];
            if (links[idx] == 0) begin
               links[idx] = next_node[5:0];
               next_node++;
            end
            node = links[idx];
            pfx_cnt[node]++;
         end
         end_cnt[node]++;
         return ST_OK;
      endfunction

      function void delete_word();
         int unsigned node;
         int unsigned matched;
         int unsigned cur;
         int unsigned parent;
         bit full;
         matched = walk(node, full);
         end_cnt[node]--;
         for (int i = n_letters; i > 0; i--) begin
            cur = path[i-1];
            parent = (i >= 2) ? path[i-2] : 0;
            pfx_cnt[cur]--;
            if (pfx_cnt[cur] == 0) links[parent*ALPHA + letters[i-1]] = 0;
         end
      endfunction

      function void note_beat(logic [1:0] kind, logic [4:0] letter, bit no_letter, bit last);
         logic [2:0] status;
         bit found;
         if (!no_letter) begin
            if (n_letters < MAX_LEN) begin
               letters[n_letters] = (letter > LETTER_Z) ? 5'(LETTER_Z) : letter;
               n_letters++;
            end else begin
               overlong = 1;
            end
         end
         if (!last) return;
         found = 0;
         status = ST_OK;
         if (overlong) status = ST_TOO_LONG;
         else if (kind == OP_INSERT) status = insert_word();
         else if (kind == OP_DELETE) begin
            if (present()) delete_word();
            else status = ST_ABSENT;
         end else begin
            if (present()) found = 1;
            else status = ST_ABSENT;
         end
         n_letters = 0;
         overlong = 0;
         expected_rsp.push_back({status, found});
      endfunction

      function void check_result(bit found, logic [2:0] status);
         bit [3:0] want;
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected response found=%0d status=%0d", found, status));
            return;
         end
         want = expected_rsp.pop_front();
         if (found !== want[0])
            report($sformatf("found is %0d, expected %0d", found, want[0]));
         if (status !== want[3:1])
            report($sformatf("status is %0d, expected %0d", status, want[3:1]));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [4:0] letter, zero padded
   logic [2:0] req_tuser;   // [1:0] req_type, [2] no_letter
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] found, [3:1] status, zero padded

   trie_scoreboard sb = new();
   int beats_sent;
   int rsp_seen;
   bit hold_done;

   trie_string_counter DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_beat(req_tuser[1:0], req_tdata[4:0], req_tuser[2], req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata[0], rsp_tdata[3:1]);
         rsp_seen++;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: stretches of full readiness alternate with random stalls, and
   // once a long hold-off lets the block back up into its request side.
   initial begin
      int mode_left;
      int hold_left;
      bit always_ready;
      rsp_tready = 1'b0;
      mode_left = 0;
      hold_left = 0;
      always_ready = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && rsp_seen >= 200) begin
            hold_done = 1;
            hold_left = 600;
         end
         if (mode_left == 0) begin
            always_ready = $urandom_range(0, 2) == 0;
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (always_ready) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 5) begin
            rsp_tready <= 1'b0;
            hold_left = $urandom_range(10, 40);
         end else begin
            rsp_tready <= $urandom_range(0, 99) < 70;
         end
      end
   end

   task send_beat(logic [1:0] kind, logic [4:0] letter, bit no_letter, bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, letter};
      req_tuser <= {no_letter, kind};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function logic [4:0] pick_letter(int alpha_hi);
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, alpha_hi));
   endfunction

   // A string of len letters; len 0 sends the empty string as one flagged beat.
   task send_word(logic [1:0] kind, int len, int alpha_hi, bit noise);
      if (len == 0) begin
         send_beat(kind, 5'($urandom_range(0, 31)), 1'b1, 1'b1);
         return;
      end
      for (int i = 0; i < len; i++) begin
         if (noise && $urandom_range(0, 19) == 0)
            send_beat(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b1, 1'b0);
         send_beat(kind, pick_letter(alpha_hi), 1'b0, i == len - 1);
      end
   endtask

   task send_fixed(logic [1:0] kind, logic [4:0] a, logic [4:0] b, logic [4:0] c, int len);
      if (len >= 1) send_beat(kind, a, 1'b0, len == 1);
      if (len >= 2) send_beat(kind, b, 1'b0, len == 2);
      if (len >= 3) send_beat(kind, c, 1'b0, len == 3);
   endtask

   function logic [1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return OP_INSERT;
      if (r < 70) return OP_DELETE;
      if (r < 95) return OP_FIND;
      return OP_ALT_FIND;
   endfunction

   initial begin
      int r;
      int waited;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      beats_sent = 0;
      rsp_seen = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty string, clamped letters, prefixes, too long, selector three.
      send_word(OP_FIND, 0, 0, 0);
      send_word(OP_INSERT, 0, 0, 0);
      send_word(OP_FIND, 0, 0, 0);
      send_word(OP_DELETE, 0, 0, 0);
      send_word(OP_DELETE, 0, 0, 0);
      send_fixed(OP_INSERT, 5'd0, 5'd1, 5'd2, 3);
      send_fixed(OP_FIND, 5'd0, 5'd1, 5'd2, 2);
      send_fixed(OP_FIND, 5'd0, 5'd1, 5'd2, 3);
      send_fixed(OP_ALT_FIND, 5'd0, 5'd1, 5'd2, 3);
      send_fixed(OP_INSERT, 5'd31, 5'd26, 5'd0, 2);
      send_fixed(OP_FIND, 5'd25, 5'd25, 5'd0, 2);
      send_beat(OP_INSERT, 5'd3, 1'b0, 1'b0);
      send_beat(OP_FIND, 5'd17, 1'b1, 1'b0);
      send_beat(OP_INSERT, 5'd4, 1'b0, 1'b1);
      send_fixed(OP_FIND, 5'd3, 5'd4, 5'd0, 2);
      send_word(OP_INSERT, MAX_LEN, 25, 0);
      send_word(OP_INSERT, MAX_LEN + 1, 25, 0);
      send_word(OP_FIND, MAX_LEN + 3, 1, 0);
      send_fixed(OP_DELETE, 5'd0, 5'd1, 5'd2, 3);
      send_fixed(OP_DELETE, 5'd0, 5'd1, 5'd2, 3);
      send_fixed(OP_FIND, 5'd0, 5'd1, 5'd2, 3);

      // Random: mostly strings over a small alphabet so they share prefixes
      // and get deleted; the pool fills and insert refusals follow.
      while (beats_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 8) send_word(pick_kind(), 0, 0, 1);
         else if (r < 11) send_word(pick_kind(), $urandom_range(MAX_LEN + 1, MAX_LEN + 4), 3, 1);
         else if (r < 70) send_word(pick_kind(), $urandom_range(1, 4), 1, 1);
         else if (r < 92) send_word(pick_kind(), $urandom_range(1, 6), 3, 1);
         else send_word(pick_kind(), $urandom_range(1, 8), 25, 1);
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (sb.expected_rsp.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (300) @(posedge clock);
      if (sb.expected_rsp.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.expected_rsp.size()));
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

endmodule
